// ===== rtl/core/accalu_pkg.sv =====
`timescale 1ns / 1ps

package accalu_pkg;

    localparam int DATA_W = 32;
    localparam int OPC_W  = 3;
    localparam int CNT_W  = $clog2(DATA_W);
    localparam int EXP_W  = DATA_W - 1;

    localparam logic [OPC_W-1:0] OP_ADD   = 3'd0;
    localparam logic [OPC_W-1:0] OP_SUB   = 3'd1;
    localparam logic [OPC_W-1:0] OP_MUL   = 3'd2;
    localparam logic [OPC_W-1:0] OP_DIV   = 3'd3;
    localparam logic [OPC_W-1:0] OP_MOD   = 3'd4;
    localparam logic [OPC_W-1:0] OP_NEG   = 3'd5;
    localparam logic [OPC_W-1:0] OP_POW   = 3'd6;
    localparam logic [OPC_W-1:0] OP_CLEAR = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_PW_MUL,
        ST_PW_SQR,
        ST_SIGN,
        ST_DONE
    } accalu_state_t;

    typedef struct packed {
        logic [OPC_W-1:0]         opcode;
        logic signed [DATA_W-1:0] operand;
    } accalu_cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     overflow;
        logic                     divide_by_zero;
    } accalu_res_t;

endpackage

// ===== rtl/core/accumulator_integer_alu.sv =====
`timescale 1ns / 1ps

// Signed 32-bit accumulator ALU.
// A request on the cmd channel (valid/ready) carries an opcode and an operand;
// the block applies the operation to its accumulator and returns the new
// accumulator value with overflow and divide-by-zero flags on the res channel.
// Requests are taken one at a time: cmd_ready is high only while the sequencer
// is idle. States passed after acceptance, before the done state:
//   add, subtract, negate, clear, and the zero-divisor and non-positive
//   exponent cases: none; they go straight from idle to done.
//   multiply: one pass through the shared 32x32 multiplier, then sign.
//   divide, modulo: one restoring shift-subtract step per bit, then sign.
//   power: a multiply and a square step per exponent bit up to the top set bit;
//   square-and-multiply alternates the single multiplier between both products.
// The next request can be taken in the cycle after its predecessor's result is
// loaded into the output register, so requests never overlap.
// The output register holds a finished result while res_ready is low; the
// sequencer then waits with the following result until that one is taken.
// Reset clears the accumulator to zero and drops res_valid.
module accumulator_integer_alu (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  accalu_pkg::accalu_cmd_t  cmd,
    output logic                     res_valid,
    input  logic                     res_ready,
    output accalu_pkg::accalu_res_t  res
);

    import accalu_pkg::*;

    // Magnitude of a two's-complement word; the most negative value maps to
    // 2^31, which still fits as an unsigned 32-bit number.
    function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
        mag = v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    accalu_state_t state_reg, state_next;

    // Architectural accumulator plus the flags of the last operation.
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              ovf_reg, ovf_next;
    logic              dz_reg, dz_next;

    // Working registers of the sequencer. For divide, quo holds the dividend
    // shifting into the quotient and rem the partial remainder. For power,
    // quo holds the running square of the base and rem the running product.
    // For multiply, rem receives the product magnitude.
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [EXP_W-1:0]  exp_reg, exp_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [OPC_W-1:0]  opc_reg, opc_next;
    logic              neg_reg, neg_next;
    // Sticky marks: the true magnitude behind rem or quo exceeds 2^31.
    logic              rbig_reg, rbig_next;
    logic              bbig_reg, bbig_next;

    accalu_res_t       res_reg;
    logic              res_valid_reg, res_valid_next;

    logic              cmd_fire;
    logic              res_load;
    logic [DATA_W-1:0] opnd;
    logic              opnd_zero;
    logic [DATA_W:0]   add_sum;
    logic [DATA_W:0]   sub_dif;

    // Shared multiplier.
    logic [DATA_W-1:0]   mul_a;
    logic [DATA_W-1:0]   mul_b;
    logic [2*DATA_W-1:0] mul_p;
    logic                mul_big;

    // Restoring divider step.
    logic [DATA_W:0]   div_shift;
    logic [DATA_W+1:0] div_diff;
    logic              div_ge;

    // Sign application.
    logic [DATA_W-1:0] fin_mag;
    logic              fin_big;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign res_load  = (state_reg == ST_DONE) && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign opnd      = cmd.operand;
    assign opnd_zero = (opnd == '0);
    assign add_sum   = {acc_reg[DATA_W-1], acc_reg} + {opnd[DATA_W-1], opnd};
    assign sub_dif   = {acc_reg[DATA_W-1], acc_reg} - {opnd[DATA_W-1], opnd};

    always_comb
    begin
        case (state_reg)
            ST_PW_MUL:
            begin
                mul_a = rem_reg;
                mul_b = quo_reg;
            end
            ST_PW_SQR:
            begin
                mul_a = quo_reg;
                mul_b = quo_reg;
            end
            default:
            begin
                mul_a = quo_reg;
                mul_b = dvs_reg;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign mul_big = (|mul_p[2*DATA_W-1:DATA_W]) ||
                     (mul_p[DATA_W-1] && (|mul_p[DATA_W-2:0]));

    assign div_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, dvs_reg};
    assign div_ge    = !div_diff[DATA_W+1];

    assign fin_mag = (opc_reg == OP_DIV) ? quo_reg : rem_reg;
    assign fin_big = rbig_reg;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.opcode)
                        OP_MUL:
                            state_next = ST_MUL;
                        OP_DIV, OP_MOD:
                            state_next = opnd_zero ? ST_DONE : ST_DIV;
                        OP_POW:
                            state_next = (opnd_zero || opnd[DATA_W-1]) ? ST_DONE : ST_PW_MUL;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_MUL:
                state_next = ST_SIGN;
            ST_DIV:
                state_next = (cnt_reg == CNT_W'(DATA_W - 1)) ? ST_SIGN : ST_DIV;
            ST_PW_MUL:
                state_next = ST_PW_SQR;
            ST_PW_SQR:
                state_next = (exp_reg[EXP_W-1:1] == '0) ? ST_SIGN : ST_PW_MUL;
            ST_SIGN:
                state_next = ST_DONE;
            ST_DONE:
                state_next = res_load ? ST_IDLE : ST_DONE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath updates driven by the sequencer state.
    always_comb
    begin
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;
        dz_next   = dz_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        exp_next  = exp_reg;
        cnt_next  = cnt_reg;
        opc_next  = opc_reg;
        neg_next  = neg_reg;
        rbig_next = rbig_reg;
        bbig_next = bbig_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    ovf_next  = 1'b0;
                    dz_next   = 1'b0;
                    opc_next  = cmd.opcode;
                    quo_next  = mag(acc_reg);
                    dvs_next  = mag(opnd);
                    rem_next  = '0;
                    cnt_next  = '0;
                    rbig_next = 1'b0;
                    bbig_next = 1'b0;
                    neg_next  = acc_reg[DATA_W-1] ^ opnd[DATA_W-1];
                    exp_next  = opnd[EXP_W-1:0];
                    case (cmd.opcode)
                        OP_ADD:
                        begin
                            acc_next = add_sum[DATA_W-1:0];
                            ovf_next = add_sum[DATA_W] ^ add_sum[DATA_W-1];
                        end
                        OP_SUB:
                        begin
                            acc_next = sub_dif[DATA_W-1:0];
                            ovf_next = sub_dif[DATA_W] ^ sub_dif[DATA_W-1];
                        end
                        OP_NEG:
                        begin
                            acc_next = ~acc_reg + 1'b1;
                            ovf_next = acc_reg[DATA_W-1] && (acc_reg[DATA_W-2:0] == '0);
                        end
                        OP_CLEAR:
                            acc_next = '0;
                        OP_DIV, OP_MOD:
                            dz_next = opnd_zero;
                        OP_POW:
                        begin
                            // A zero exponent gives one; a negative one keeps
                            // the accumulator.
                            if (opnd_zero)
                            begin
                                acc_next = DATA_W'(1);
                            end
                            rem_next = DATA_W'(1);
                            neg_next = acc_reg[DATA_W-1] && opnd[0];
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                rem_next  = mul_p[DATA_W-1:0];
                rbig_next = mul_big;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                quo_next = {quo_reg[DATA_W-2:0], div_ge};
                rem_next = div_ge ? div_diff[DATA_W-1:0] : div_shift[DATA_W-1:0];
            end
            ST_PW_MUL:
            begin
                if (exp_reg[0])
                begin
                    rem_next  = mul_p[DATA_W-1:0];
                    rbig_next = rbig_reg || bbig_reg || mul_big;
                end
            end
            ST_PW_SQR:
            begin
                quo_next  = mul_p[DATA_W-1:0];
                bbig_next = bbig_reg || mul_big;
                exp_next  = {1'b0, exp_reg[EXP_W-1:1]};
            end
            ST_SIGN:
            begin
                if (opc_reg == OP_MOD)
                begin
                    acc_next = rem_reg;
                    ovf_next = 1'b0;
                end
                else
                begin
                    // Exactly 2^31 is in range only for a negative result.
                    acc_next = neg_reg ? (~fin_mag + 1'b1) : fin_mag;
                    ovf_next = fin_big || (fin_mag[DATA_W-1] && !neg_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg && !res_ready;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            dz_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            dz_reg        <= dz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        exp_reg  <= exp_next;
        cnt_reg  <= cnt_next;
        opc_reg  <= opc_next;
        neg_reg  <= neg_next;
        rbig_reg <= rbig_next;
        bbig_reg <= bbig_next;
        if (res_load)
        begin
            res_reg.result         <= acc_reg;
            res_reg.overflow       <= ovf_reg;
            res_reg.divide_by_zero <= dz_reg;
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the accumulator ALU.
// Requests go in on the cmd channel and results come back on the res channel.
// Every accepted request is run through a shadow accumulator that computes the
// expected result and flags. Every accepted result is compared with the oldest
// prediction still waiting.
module testbench;
    import accalu_pkg::*;

    localparam int ITEM_COUNT    = 1700;
    localparam int IDLE_PERCENT  = 34;
    // A single power request is the longest kind. The limit covers one several
    // times over, plus long random stalls on either side.
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 100;

    localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;
    localparam longint WORD_MIN = -64'sd2147483648;
    localparam longint WORD_MAX = 64'sd2147483647;

    // The shadow accumulator and the list of results it still expects to see.
    class alu_result_checker;
        logic signed [DATA_W-1:0] acc_shadow;
        accalu_res_t              expected_results[$];
        int                       errors;

        function new();
            acc_shadow = '0;
            errors     = 0;
        endfunction

        function bit exceeds_word(longint v);
            return (v < WORD_MIN) || (v > WORD_MAX);
        endfunction

        // Applies one request to the shadow accumulator. The arithmetic is done
        // in 64 bits so that the true result is available for the overflow
        // flag, and the low 32 bits are kept as the wrapped value.
        function accalu_res_t compute_alu_result(accalu_cmd_t req);
            accalu_res_t       r;
            longint            a;
            longint            b;
            longint            t;
            longint            ua;
            longint            ub;
            longint            running;
            logic [DATA_W-1:0] product;
            logic [DATA_W-1:0] square;
            logic [DATA_W-1:0] bits_left;
            a = acc_shadow;
            b = req.operand;
            r.result         = acc_shadow;
            r.overflow       = 1'b0;
            r.divide_by_zero = 1'b0;
            case (req.opcode)
                OP_ADD:
                begin
                    t = a + b;
                    r.result   = t[DATA_W-1:0];
                    r.overflow = exceeds_word(t);
                end
                OP_SUB:
                begin
                    t = a - b;
                    r.result   = t[DATA_W-1:0];
                    r.overflow = exceeds_word(t);
                end
                OP_MUL:
                begin
                    t = a * b;
                    r.result   = t[DATA_W-1:0];
                    r.overflow = exceeds_word(t);
                end
                OP_DIV:
                begin
                    if (b == 0)
                    begin
                        r.divide_by_zero = 1'b1;
                    end
                    else
                    begin
                        t = a / b;
                        r.result   = t[DATA_W-1:0];
                        r.overflow = exceeds_word(t);
                    end
                end
                OP_MOD:
                begin
                    ua = (a < 0) ? -a : a;
                    ub = (b < 0) ? -b : b;
                    if (ub == 0)
                        r.divide_by_zero = 1'b1;
                    else
                        r.result = DATA_W'(ua % ub);
                end
                OP_NEG:
                begin
                    t = -a;
                    r.result   = t[DATA_W-1:0];
                    r.overflow = exceeds_word(t);
                end
                OP_POW:
                begin
                    if (b == 0)
                    begin
                        r.result = 1;
                    end
                    else if (b > 0)
                    begin
                        // The wrapped value is the power modulo 2^32.
                        product   = 1;
                        square    = acc_shadow;
                        bits_left = req.operand;
                        for (int i = 0; i < DATA_W; i++)
                        begin
                            if (bits_left[0])
                                product = product * square;
                            square    = square * square;
                            bits_left = bits_left >> 1;
                        end
                        r.result = product;
                        // Bases -1, 0 and 1 never overflow. Any other base with an
                        // exponent of 32 or more always does. Otherwise the true
                        // power is built up step by step until it leaves range.
                        if (a < -1 || a > 1)
                        begin
                            if (b >= DATA_W)
                            begin
                                r.overflow = 1'b1;
                            end
                            else
                            begin
                                running = 1;
                                for (int k = 0; k < b; k++)
                                begin
                                    running = running * a;
                                    if (running > -WORD_MIN || running < WORD_MIN)
                                    begin
                                        r.overflow = 1'b1;
                                        break;
                                    end
                                end
                                if (!r.overflow)
                                    r.overflow = exceeds_word(running);
                            end
                        end
                    end
                end
                default:
                begin
                    r.result = '0;
                end
            endcase
            acc_shadow = r.result;
            return r;
        endfunction

        function void note_request(accalu_cmd_t req);
            expected_results.push_back(compute_alu_result(req));
        endfunction

        function void check_result(accalu_res_t got);
            accalu_res_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected, got %0d ovf %0b dz %0b",
                         $time, got.result, got.overflow, got.divide_by_zero);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.result !== want.result)
            begin
                $display("%0t: result mismatch, expected %0d, got %0d",
                         $time, want.result, got.result);
                errors++;
            end
            if (got.overflow !== want.overflow)
            begin
                $display("%0t: overflow mismatch, expected %0b, got %0b",
                         $time, want.overflow, got.overflow);
                errors++;
            end
            if (got.divide_by_zero !== want.divide_by_zero)
            begin
                $display("%0t: divide_by_zero mismatch, expected %0b, got %0b",
                         $time, want.divide_by_zero, got.divide_by_zero);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_ready;
    accalu_cmd_t cmd;
    logic        res_valid;
    logic        res_ready;
    accalu_res_t res;

    alu_result_checker sb;
    int                requests_sent = 0;
    int                quiet_cycles  = 0;
    // While this is set, neither side inserts idle cycles.
    bit                steady_phase  = 1'b0;

    accumulator_integer_alu DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Both channels are sampled at the rising edge, where the values seen are
    // the ones that held just before it. A result is checked before a request
    // at the same edge is noted, so that a stray result cannot consume a
    // prediction made for a request that is only now being accepted.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            sb.check_result(res);
        if (rst_n && cmd_valid && cmd_ready)
            sb.note_request(cmd);
    end

    // The result side stalls at random, except during the steady stretch.
    always @(posedge clk)
    begin
        res_ready <= steady_phase || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Ends the run when neither channel has moved anything for too long.
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("accumulator_integer_alu regression: fail");
            $finish;
        end
    end

    // Presents one request and returns at the edge where it is accepted. A
    // random number of idle cycles comes first outside the steady stretch, during
    // which the payload carries garbage so that the block is seen to ignore it.
    task automatic send_request(input logic [OPC_W-1:0]         opc,
                                input logic signed [DATA_W-1:0] value);
        int gap;
        gap = 0;
        if (!steady_phase)
        begin
            while ($urandom_range(99) < IDLE_PERCENT)
                gap++;
        end
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap)
            begin
                cmd.opcode  <= OPC_W'($urandom);
                cmd.operand <= $urandom;
                @(posedge clk);
            end
        end
        cmd_valid   <= 1'b1;
        cmd.opcode  <= opc;
        cmd.operand <= value;
        do
            @(posedge clk);
        while (!cmd_ready);
        requests_sent++;
    endtask

    // Holds the request side quiet until every predicted result has arrived.
    // At least one edge passes first, so that the request accepted just now
    // has been noted and valid is never lowered and raised in the same step.
    task automatic wait_for_results();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Operands are fully random in four cases of ten, with extra weight on the extremes
    // and on small values. Power mostly gets exponents that make the overflow
    // check work step by step, and sometimes negative or huge ones.
    function automatic logic signed [DATA_W-1:0] pick_operand(logic [OPC_W-1:0] opc);
        if (opc == OP_POW)
        begin
            case ($urandom_range(9))
                0:       return -$signed(32'($urandom_range(1000)));
                1:       return $urandom;
                2:       return 0;
                default: return $urandom_range(40);
            endcase
        end
        case ($urandom_range(9))
            0:       return MAX_VAL;
            1:       return MIN_VAL;
            2:       return 0;
            3:       return -1;
            4, 5:    return int'($urandom_range(16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [OPC_W-1:0] opc;
        sb = new();
        rst_n       <= 1'b0;
        cmd_valid   <= 1'b0;
        cmd         <= '0;
        res_ready   <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: the corner cases of each operation, in an order that
        // sets up the accumulator each one needs.
        send_request(OP_CLEAR, 0);
        send_request(OP_POW,   0);            // zero exponent gives one, base zero
        send_request(OP_ADD,   MAX_VAL);      // one plus max wraps to min
        send_request(OP_NEG,   $urandom);     // negating min stays min, overflow
        send_request(OP_DIV,   -1);           // min over minus one wraps, overflow
        send_request(OP_DIV,   0);            // divide by zero
        send_request(OP_MOD,   0);            // modulo by zero
        send_request(OP_MOD,   -7);           // magnitude remainder of min
        send_request(OP_SUB,   MIN_VAL);
        send_request(OP_MUL,   MAX_VAL);
        send_request(OP_CLEAR, $urandom);
        send_request(OP_ADD,   -2);
        send_request(OP_POW,   31);           // exactly min, no overflow
        send_request(OP_CLEAR, 0);
        send_request(OP_ADD,   2);
        send_request(OP_POW,   31);           // one past max, overflow
        send_request(OP_POW,   -5);           // negative exponent leaves it alone
        send_request(OP_CLEAR, 0);
        send_request(OP_ADD,   3);
        send_request(OP_POW,   40);           // large exponent always overflows
        send_request(OP_CLEAR, 0);
        send_request(OP_SUB,   1);
        send_request(OP_POW,   MAX_VAL);      // minus one to an odd power
        send_request(OP_MUL,   MIN_VAL);      // minus one times min, overflow
        send_request(OP_MOD,   MIN_VAL);
        wait_for_results();

        // Random part. Now and then the accumulator is reloaded with a fresh
        // value, often a small one, so that power and multiply see bases that
        // neither collapse to zero nor overflow at once.
        while (requests_sent < ITEM_COUNT)
        begin
            steady_phase = (requests_sent >= 700) && (requests_sent < 1000);
            if ($urandom_range(99) < 15)
            begin
                send_request(OP_CLEAR, $urandom);
                if ($urandom_range(1) == 0)
                    send_request(OP_ADD, int'($urandom_range(20)) - 10);
                else
                    send_request(OP_ADD, $urandom);
            end
            opc = OPC_W'($urandom_range(OP_CLEAR, OP_ADD));
            send_request(opc, pick_operand(opc));
            if ($urandom_range(99) == 0)
                wait_for_results();
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("accumulator_integer_alu regression: pass");
        else
            $display("accumulator_integer_alu regression: fail");
        $finish;
    end

endmodule
